// ===== design/tle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tle_pkg;

  // Field widths fixed by the instruction and result formats
  localparam int REQ_TYPE_W = 4;
  localparam int OFFSET_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int NEXT_PC_W  = 14;
  localparam int STATUS_W   = 3;
  localparam int EOF_MODE_W = 2;

  // Request codes
  localparam logic [REQ_TYPE_W-1:0] OP_END    = 4'd0;
  localparam logic [REQ_TYPE_W-1:0] OP_SET    = 4'd1;
  localparam logic [REQ_TYPE_W-1:0] OP_ADD    = 4'd2;
  localparam logic [REQ_TYPE_W-1:0] OP_JZ     = 4'd3;
  localparam logic [REQ_TYPE_W-1:0] OP_JNZ    = 4'd4;
  localparam logic [REQ_TYPE_W-1:0] OP_SCAN   = 4'd5;
  localparam logic [REQ_TYPE_W-1:0] OP_MOVE   = 4'd6;
  localparam logic [REQ_TYPE_W-1:0] OP_OUT    = 4'd7;
  localparam logic [REQ_TYPE_W-1:0] OP_IN     = 4'd8;
  localparam logic [REQ_TYPE_W-1:0] OP_ASSERT = 4'd9;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_RUN    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ENDED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ASSERT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EOF    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_HANG   = 3'd4;

  // End-of-input modes
  localparam logic [EOF_MODE_W-1:0] EOF_FF    = 2'd0;
  localparam logic [EOF_MODE_W-1:0] EOF_ZERO  = 2'd1;
  localparam logic [EOF_MODE_W-1:0] EOF_KEEP  = 2'd2;
  localparam logic [EOF_MODE_W-1:0] EOF_STOP  = 2'd3;
  localparam logic [EOF_MODE_W-1:0] EOF_RESET = EOF_KEEP;

  typedef enum logic [1:0] {
    CLEAR_S,
    IDLE_S,
    EXEC_S,
    SCAN_S
  } state_t;

  // Tape read address source
  typedef enum logic [1:0] {
    RD_REQ,
    RD_CUR,
    RD_NEXT
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    scan_first;
    logic    scan_step;
    logic    finish;
    logic    clr_wr;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic scan_go;
    logic scan_done;
    logic res_busy;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/tle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire tle_pkg::sts_t sts,
  output tle_pkg::cmd_t      cmd
);

  tle_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tle_pkg::CLEAR_S;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next     = state;
    req_stall      = 1'b1;
    cmd.latch      = 1'b0;
    cmd.scan_first = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.finish     = 1'b0;
    cmd.clr_wr     = 1'b0;
    cmd.rd_sel     = tle_pkg::RD_CUR;
    case (state)
      tle_pkg::CLEAR_S: begin
        // sweep zeros through the tape
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = tle_pkg::IDLE_S;
        end
      end
      tle_pkg::IDLE_S: begin
        req_stall  = 1'b0;
        cmd.rd_sel = tle_pkg::RD_REQ;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = tle_pkg::EXEC_S;
        end
      end
      tle_pkg::EXEC_S: begin
        if (sts.scan_go) begin
          cmd.scan_first = 1'b1;
          cmd.rd_sel     = tle_pkg::RD_NEXT;
          state_next     = tle_pkg::SCAN_S;
        end else if (!sts.res_busy) begin
          cmd.finish = 1'b1;
          state_next = tle_pkg::IDLE_S;
        end
      end
      tle_pkg::SCAN_S: begin
        if (!sts.scan_done) begin
          // advance one stride per cycle
          cmd.scan_step = 1'b1;
          cmd.rd_sel    = tle_pkg::RD_NEXT;
        end else if (!sts.res_busy) begin
          cmd.finish = 1'b1;
          state_next = tle_pkg::IDLE_S;
        end
      end
      default: begin
        state_next = tle_pkg::IDLE_S;
      end
    endcase
  end

  // Assertions
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !sts.res_busy)
    else $error("result issued into a stalled output register");

  a_step_not_done: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_step |-> !sts.scan_done)
    else $error("scan advanced after its end");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> state == tle_pkg::EXEC_S)
    else $error("transfer accepted without moving to execute");

endmodule

`default_nettype wire

// ===== design/tle_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tle_datapath #(
  parameter int TAPE_AW = 16,
  parameter int PC_AW   = 14
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire tle_pkg::cmd_t                         cmd,
  output tle_pkg::sts_t                              sts,
  input  wire logic [tle_pkg::REQ_TYPE_W-1:0]        req_type,
  input  wire logic signed [tle_pkg::OFFSET_W-1:0]   move_offset,
  input  wire logic signed [tle_pkg::OFFSET_W-1:0]   operand,
  input  wire logic [tle_pkg::BYTE_W-1:0]            in_byte,
  input  wire logic                                  in_eof,
  input  wire logic                                  eof_mode_we,
  input  wire logic [tle_pkg::EOF_MODE_W-1:0]        eof_mode_wdata,
  input  wire logic                                  res_stall,
  output logic                                       res_valid,
  output logic [tle_pkg::NEXT_PC_W-1:0]              next_pc,
  output logic                                       out_valid,
  output logic [tle_pkg::BYTE_W-1:0]                 out_byte,
  output logic [tle_pkg::STATUS_W-1:0]               status
);

  localparam int TAPE_SIZE = 1 << TAPE_AW;
  localparam int CNT_W     = TAPE_AW + 1;

  logic [tle_pkg::BYTE_W-1:0]     tape [TAPE_SIZE];

  logic [TAPE_AW-1:0]             ptr, cur, clr_addr;
  logic [TAPE_AW-1:0]             req_addr, step_addr, rd_addr, wr_addr, ptr_c;
  logic [CNT_W-1:0]               cnt;
  logic [tle_pkg::REQ_TYPE_W-1:0] op;
  logic [tle_pkg::OFFSET_W-1:0]   arg;
  logic [tle_pkg::BYTE_W-1:0]     inb;
  logic                           eof;
  logic [PC_AW-1:0]               pc, pc_inc, tgt_inc, next_c;
  logic                           halted;
  logic [tle_pkg::EOF_MODE_W-1:0] eof_mode;
  logic [tle_pkg::BYTE_W-1:0]     rd_data, wr_data, op_data;
  logic                           mem_we, op_wr, ov_c;
  logic [tle_pkg::BYTE_W-1:0]     ob_c;
  logic [tle_pkg::STATUS_W-1:0]   status_c;

  // Address arithmetic wraps at the tape size
  assign req_addr  = ptr + TAPE_AW'(move_offset);
  assign step_addr = cur + TAPE_AW'(arg);

  always_comb begin
    case (cmd.rd_sel)
      tle_pkg::RD_REQ:  rd_addr = req_addr;
      tle_pkg::RD_NEXT: rd_addr = step_addr;
      default:          rd_addr = cur;
    endcase
  end

  assign mem_we  = cmd.clr_wr | (cmd.finish & op_wr);
  assign wr_addr = cmd.clr_wr ? clr_addr : cur;
  assign wr_data = cmd.clr_wr ? '0 : op_data;

  // Tape memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tape[wr_addr] <= wr_data;
    end
    rd_data <= tape[rd_addr];
  end

  // Decode the current instruction against the cell read back
  assign pc_inc  = pc + PC_AW'(1);
  assign tgt_inc = PC_AW'(arg) + PC_AW'(1);

  always_comb begin
    status_c = tle_pkg::ST_RUN;
    ov_c     = 1'b0;
    ob_c     = '0;
    op_wr    = 1'b0;
    op_data  = '0;
    next_c   = pc_inc;
    ptr_c    = cur;
    case (op)
      tle_pkg::OP_END: begin
        status_c = tle_pkg::ST_ENDED;
      end
      tle_pkg::OP_SET: begin
        op_wr   = 1'b1;
        op_data = arg[tle_pkg::BYTE_W-1:0];
      end
      tle_pkg::OP_ADD: begin
        op_wr   = 1'b1;
        op_data = rd_data + arg[tle_pkg::BYTE_W-1:0];
      end
      tle_pkg::OP_JZ: begin
        if (rd_data == '0) begin
          next_c = tgt_inc;
        end
      end
      tle_pkg::OP_JNZ: begin
        if (rd_data != '0) begin
          next_c = tgt_inc;
        end
      end
      tle_pkg::OP_SCAN: begin
        // a scan that ends on a nonzero cell has hung
        if (rd_data != '0) begin
          status_c = tle_pkg::ST_HANG;
        end
      end
      tle_pkg::OP_MOVE: begin
        ptr_c = step_addr;
      end
      tle_pkg::OP_OUT: begin
        ov_c = 1'b1;
        ob_c = rd_data;
      end
      tle_pkg::OP_IN: begin
        if (!eof) begin
          op_wr   = 1'b1;
          op_data = inb;
        end else begin
          case (eof_mode)
            tle_pkg::EOF_FF: begin
              op_wr   = 1'b1;
              op_data = '1;
            end
            tle_pkg::EOF_ZERO: begin
              op_wr = 1'b1;
            end
            tle_pkg::EOF_STOP: begin
              status_c = tle_pkg::ST_EOF;
            end
            default: begin
            end
          endcase
        end
      end
      tle_pkg::OP_ASSERT: begin
        if (rd_data != '0) begin
          status_c = tle_pkg::ST_ASSERT;
        end
      end
      default: begin
      end
    endcase
    // halted: ignore the instruction
    if (halted) begin
      status_c = tle_pkg::ST_ENDED;
      ov_c     = 1'b0;
      ob_c     = '0;
      op_wr    = 1'b0;
    end
  end

  // Status back to the controller
  assign sts.scan_go   = !halted && (op == tle_pkg::OP_SCAN) &&
                         (TAPE_AW'(arg) != '0) && (rd_data != '0);
  assign sts.scan_done = (rd_data == '0) || cnt[TAPE_AW];
  assign sts.res_busy  = res_valid && res_stall;
  assign sts.clr_last  = (clr_addr == '1);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      eof_mode <= tle_pkg::EOF_RESET;
    end else if (eof_mode_we) begin
      eof_mode <= eof_mode_wdata;
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_wr) begin
      clr_addr <= clr_addr + TAPE_AW'(1);
    end
  end

  // Latch the instruction fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= req_type;
      arg <= operand;
      inb <= in_byte;
      eof <= in_eof;
    end
  end

  // Working pointer and scan stride count
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      cnt <= '0;
    end else if (cmd.latch) begin
      cur <= req_addr;
    end else if (cmd.scan_first) begin
      cur <= step_addr;
      cnt <= CNT_W'(1);
    end else if (cmd.scan_step) begin
      cur <= step_addr;
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Architectural state: commit at finish
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      pc     <= '0;
      halted <= 1'b0;
    end else if (cmd.finish && !halted) begin
      ptr <= ptr_c;
      if (status_c != tle_pkg::ST_RUN) begin
        halted <= 1'b1;
      end else begin
        pc <= next_c;
      end
    end
  end

  // Output register: load at finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.finish) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      next_pc   <= tle_pkg::NEXT_PC_W'((status_c != tle_pkg::ST_RUN) ? pc : next_c);
      out_valid <= ov_c;
      out_byte  <= ob_c;
      status    <= status_c;
    end
  end

  // Assertions
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag dropped without reset");

  a_halt_on_status: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && !halted && (status_c != tle_pkg::ST_RUN)) |=> halted)
    else $error("halting result did not set halted");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt[TAPE_AW] |-> (cnt[TAPE_AW-1:0] == '0))
    else $error("scan count passed one full tape walk");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |-> !mem_we)
    else $error("tape written while accepting an instruction");

endmodule

`default_nettype wire

// ===== design/tape_language_executor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Tape language executor: runs one pre-decoded instruction per transfer.
// Request channel: req_valid / req_stall with req_type, move_offset, operand,
// in_byte and in_eof. Result channel: res_valid / res_stall with next_pc,
// out_valid, out_byte and status; every instruction yields one result.
// eof_mode is written through eof_mode_we / eof_mode_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
// Flow: an instruction is accepted in the idle state, reads its tape cell
// from the synchronous tape memory at that edge, executes in the execute
// state and loads its result into the output register once that is free;
// only then is a new instruction taken. A scan walks its strides with one
// tape read per cycle, up to 2^TAPE_AW strides before it reports a hang.
// Reset: state, pointer and program counter clear, and a clearing pass
// writes zero to every cell, one per cycle; req_stall stays high meanwhile.
// When res_stall holds the output register, the next instruction is still
// accepted and executed up to its result, which waits until the register
// frees.

module tape_language_executor_unit #(
  parameter int TAPE_AW = 16,
  parameter int PC_AW   = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [tle_pkg::REQ_TYPE_W-1:0]      req_type,
  input  wire logic signed [tle_pkg::OFFSET_W-1:0] move_offset,
  input  wire logic signed [tle_pkg::OFFSET_W-1:0] operand,
  input  wire logic [tle_pkg::BYTE_W-1:0]          in_byte,
  input  wire logic                                in_eof,
  input  wire logic                                eof_mode_we,
  input  wire logic [tle_pkg::EOF_MODE_W-1:0]      eof_mode_wdata,
  output logic                                     res_valid,
  input  wire logic                                res_stall,
  output logic [tle_pkg::NEXT_PC_W-1:0]            next_pc,
  output logic                                     out_valid,
  output logic [tle_pkg::BYTE_W-1:0]               out_byte,
  output logic [tle_pkg::STATUS_W-1:0]             status
);

  tle_pkg::cmd_t cmd;
  tle_pkg::sts_t sts;

  tle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tle_datapath #(
    .TAPE_AW (TAPE_AW),
    .PC_AW   (PC_AW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .req_type       (req_type),
    .move_offset    (move_offset),
    .operand        (operand),
    .in_byte        (in_byte),
    .in_eof         (in_eof),
    .eof_mode_we    (eof_mode_we),
    .eof_mode_wdata (eof_mode_wdata),
    .res_stall      (res_stall),
    .res_valid      (res_valid),
    .next_pc        (next_pc),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .status         (status)
  );

endmodule

`default_nettype wire

// ===== tb/tape_language_executor_unit_tb.sv =====
`timescale 1ns / 1ps

module tape_language_executor_unit_tb;

  localparam int CELLS = 1 << tle_pkg::OFFSET_W;

  // Request codes with no operation behind them
  localparam logic [tle_pkg::REQ_TYPE_W-1:0] OP_SPARE_LO = tle_pkg::OP_ASSERT + 4'd1;
  localparam logic [tle_pkg::REQ_TYPE_W-1:0] OP_SPARE_HI = '1;

  typedef struct packed {
    logic [tle_pkg::REQ_TYPE_W-1:0]      op;
    logic signed [tle_pkg::OFFSET_W-1:0] offs;
    logic signed [tle_pkg::OFFSET_W-1:0] arg;
    logic [tle_pkg::BYTE_W-1:0]          inb;
    logic                                eof;
  } instr_t;

  typedef struct packed {
    logic [tle_pkg::NEXT_PC_W-1:0] pc;
    logic                          valid;
    logic [tle_pkg::BYTE_W-1:0]    data;
    logic [tle_pkg::STATUS_W-1:0]  code;
  } result_t;

  typedef enum int {
    HALT_END,
    HALT_ASSERT,
    HALT_EOF,
    HALT_FLAT,
    HALT_WALK
  } halt_kind_t;

  // Tape machine mirror plus the queue of results still owed by the block
  class tape_scoreboard;
    logic [tle_pkg::BYTE_W-1:0]     cells [0:CELLS-1];
    logic [tle_pkg::OFFSET_W-1:0]   ptr;
    logic [tle_pkg::NEXT_PC_W-1:0]  pc;
    logic                           halted;
    logic [tle_pkg::EOF_MODE_W-1:0] eof_mode;
    result_t                        expected_results[$];
    int                             mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      ptr        = '0;
      pc         = '0;
      halted     = 1'b0;
      eof_mode   = tle_pkg::EOF_RESET;
      mismatches = 0;
    endfunction

    // Work out the result of one instruction; update the state only on commit
    function result_t execute_instr(instr_t it, bit commit);
      result_t                       r;
      logic [tle_pkg::OFFSET_W-1:0]  p;
      logic [tle_pkg::NEXT_PC_W-1:0] nxt;
      int unsigned                   walked;
      r = '0;
      if (halted) begin
        r.pc   = pc;
        r.code = tle_pkg::ST_ENDED;
        return r;
      end
      nxt = pc + 14'd1;
      p   = ptr + it.offs;
      case (it.op)
        tle_pkg::OP_END: r.code = tle_pkg::ST_ENDED;
        tle_pkg::OP_SET: if (commit) cells[p] = it.arg[tle_pkg::BYTE_W-1:0];
        tle_pkg::OP_ADD: if (commit) cells[p] = cells[p] + it.arg[tle_pkg::BYTE_W-1:0];
        tle_pkg::OP_JZ: if (cells[p] == 0) nxt = it.arg[tle_pkg::NEXT_PC_W-1:0] + 14'd1;
        tle_pkg::OP_JNZ: if (cells[p] != 0) nxt = it.arg[tle_pkg::NEXT_PC_W-1:0] + 14'd1;
        tle_pkg::OP_SCAN: begin
          // walk by the stride until a zero cell, at most one lap of strides
          walked = 0;
          if (it.arg != 0) begin
            while (cells[p] != 0 && walked < CELLS) begin
              p = p + it.arg;
              walked++;
            end
          end
          if (cells[p] != 0) r.code = tle_pkg::ST_HANG;
        end
        tle_pkg::OP_MOVE: p = p + it.arg;
        tle_pkg::OP_OUT: begin
          r.valid = 1'b1;
          r.data  = cells[p];
        end
        tle_pkg::OP_IN: begin
          if (!it.eof) begin
            if (commit) cells[p] = it.inb;
          end else begin
            case (eof_mode)
              tle_pkg::EOF_FF:   if (commit) cells[p] = 8'hFF;
              tle_pkg::EOF_ZERO: if (commit) cells[p] = 8'h00;
              tle_pkg::EOF_STOP: r.code = tle_pkg::ST_EOF;
              default:  ;
            endcase
          end
        end
        tle_pkg::OP_ASSERT: if (cells[p] != 0) r.code = tle_pkg::ST_ASSERT;
        default: ;
      endcase
      // a halting instruction keeps the program counter on itself
      r.pc = (r.code != tle_pkg::ST_RUN) ? pc : nxt;
      if (commit) begin
        ptr = p;
        if (r.code != tle_pkg::ST_RUN) halted = 1'b1;
        else pc = nxt;
      end
      return r;
    endfunction

    function void note_request(instr_t it);
      expected_results.push_back(execute_instr(it, 1'b1));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected: pc %0d valid %0d byte %0h status %0d",
                 $time, got.pc, got.valid, got.data, got.code);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      if (got.pc != want.pc) begin
        $display("%0t: next_pc expected %0d actual %0d", $time, want.pc, got.pc);
        mismatches++;
      end
      if (got.valid != want.valid) begin
        $display("%0t: out_valid expected %0d actual %0d", $time, want.valid, got.valid);
        mismatches++;
      end
      if (got.data != want.data) begin
        $display("%0t: out_byte expected %0h actual %0h", $time, want.data, got.data);
        mismatches++;
      end
      if (got.code != want.code) begin
        $display("%0t: status expected %0d actual %0d", $time, want.code, got.code);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst;
  logic                                req_valid;
  logic                                req_stall;
  logic [tle_pkg::REQ_TYPE_W-1:0]      req_type;
  logic signed [tle_pkg::OFFSET_W-1:0] move_offset;
  logic signed [tle_pkg::OFFSET_W-1:0] operand;
  logic [tle_pkg::BYTE_W-1:0]          in_byte;
  logic                                in_eof;
  logic                                eof_mode_we;
  logic [tle_pkg::EOF_MODE_W-1:0]      eof_mode_wdata;
  logic                                res_valid;
  logic                                res_stall;
  logic [tle_pkg::NEXT_PC_W-1:0]       next_pc;
  logic                                out_valid;
  logic [tle_pkg::BYTE_W-1:0]          out_byte;
  logic [tle_pkg::STATUS_W-1:0]        status;

  tape_scoreboard sb;
  int             tx_idle_pct;
  int             rx_idle_pct;
  bit             rx_hold_req;

  tape_language_executor_unit i_dut (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .req_type       (req_type),
    .move_offset    (move_offset),
    .operand        (operand),
    .in_byte        (in_byte),
    .in_eof         (in_eof),
    .eof_mode_we    (eof_mode_we),
    .eof_mode_wdata (eof_mode_wdata),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .next_pc        (next_pc),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .status         (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random; hold it off for a long stretch on request
  initial begin
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (300) @(negedge clk);
      end
      res_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Check every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      sb.check_result('{pc: next_pc, valid: out_valid, data: out_byte, code: status});
    end
  end

  // Offer one instruction and note it on the transfer; return at a falling edge
  task automatic send(input instr_t it);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_valid   <= 1'b1;
    req_type    <= it.op;
    move_offset <= it.offs;
    operand     <= it.arg;
    in_byte     <= it.inb;
    in_eof      <= it.eof;
    do @(posedge clk); while (req_stall);
    sb.note_request(it);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [tle_pkg::REQ_TYPE_W-1:0] op,
                             input logic [tle_pkg::OFFSET_W-1:0] offs,
                             input logic [tle_pkg::OFFSET_W-1:0] arg,
                             input logic [tle_pkg::BYTE_W-1:0] inb, input logic eof);
    send('{op: op, offs: offs, arg: arg, inb: inb, eof: eof});
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_eof_mode(input logic [tle_pkg::EOF_MODE_W-1:0] mode);
    eof_mode_we    <= 1'b1;
    eof_mode_wdata <= mode;
    @(negedge clk);
    eof_mode_we <= 1'b0;
    sb.eof_mode = mode;
  endtask

  // Mostly small pointer moves and strides so cells get reused
  function automatic instr_t rand_instr();
    instr_t      it;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    it.inb  = tle_pkg::BYTE_W'($urandom);
    it.eof  = ($urandom_range(0, 3) == 0);
    it.arg  = tle_pkg::OFFSET_W'($urandom);
    it.offs = ($urandom_range(0, 6) == 0) ? tle_pkg::OFFSET_W'($urandom)
                                          : tle_pkg::OFFSET_W'($urandom_range(0, 8) - 4);
    if (pick < 16)      it.op = tle_pkg::OP_SET;
    else if (pick < 32) it.op = tle_pkg::OP_ADD;
    else if (pick < 40) it.op = tle_pkg::OP_JZ;
    else if (pick < 47) it.op = tle_pkg::OP_JNZ;
    else if (pick < 62) it.op = tle_pkg::OP_SCAN;
    else if (pick < 70) it.op = tle_pkg::OP_MOVE;
    else if (pick < 81) it.op = tle_pkg::OP_OUT;
    else if (pick < 91) it.op = tle_pkg::OP_IN;
    else if (pick < 96) it.op = tle_pkg::OP_ASSERT;
    else it.op = tle_pkg::REQ_TYPE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if ((it.op == tle_pkg::OP_SCAN || it.op == tle_pkg::OP_MOVE) &&
        $urandom_range(0, 3) != 0) begin
      it.arg = tle_pkg::OFFSET_W'($urandom_range(0, 6) - 3);
    end
    return it;
  endfunction

  // Random instructions that keep the machine running
  task automatic random_burst(input int count, input int hold_at, input int pause_at);
    instr_t  it;
    result_t probe;
    for (int i = 0; i < count; i++) begin
      do begin
        it    = rand_instr();
        probe = sb.execute_instr(it, 1'b0);
      end while (probe.code != tle_pkg::ST_RUN);
      if (i == hold_at) rx_hold_req = 1'b1;
      if (i == pause_at) drain();
      send(it);
    end
  endtask

  initial begin
    halt_kind_t kind;
    instr_t     it;
    sb             = new();
    rst            = 1'b1;
    req_valid      = 1'b0;
    req_type       = tle_pkg::OP_END;
    move_offset    = '0;
    operand        = '0;
    in_byte        = '0;
    in_eof         = 1'b0;
    eof_mode_we    = 1'b0;
    eof_mode_wdata = tle_pkg::EOF_RESET;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    rx_hold_req    = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: cleared tape, byte wrap, pointer wrap both ways, jumps, scans, input
    send_fields(tle_pkg::OP_OUT,    16'h0000, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SET,    16'h0000, 16'h7FFF, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_ADD,    16'h0000, 16'h0001, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_ADD,    16'h0000, 16'h8081, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_OUT,    16'h0000, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_MOVE,   16'hFFFF, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SET,    16'h8000, 16'h0005, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_MOVE,   16'h0000, 16'h8000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_MOVE,   16'h0001, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_JZ,     16'h0000, 16'h3FFF, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_JNZ,    16'h0000, 16'hFFFF, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_JZ,     16'h0001, 16'h4005, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SET,    16'h0000, 16'h0007, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SET,    16'h0001, 16'h0003, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SCAN,   16'hFFFE, 16'h0001, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SCAN,   16'h0000, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_SCAN,   16'hFFFD, 16'hFFFF, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_IN,     16'h0001, 16'h0000, 8'hA5, 1'b0);
    send_fields(tle_pkg::OP_IN,     16'h0000, 16'h0000, 8'h5A, 1'b1);
    send_fields(tle_pkg::OP_OUT,    16'h0000, 16'h0000, 8'h00, 1'b0);
    send_fields(tle_pkg::OP_ASSERT, 16'h0003, 16'h0000, 8'h00, 1'b0);
    send_fields(OP_SPARE_HI,        16'h7FFF, 16'hFFFF, 8'hFF, 1'b1);
    send_fields(OP_SPARE_LO,        16'h8001, 16'h0000, 8'h00, 1'b0);

    // Receiver stalls more than the sender idles; pause once mid-way
    drain();
    write_eof_mode(tle_pkg::EOF_FF);
    tx_idle_pct = 36;
    rx_idle_pct = 67;
    random_burst(150, -1, 75);

    drain();
    write_eof_mode(tle_pkg::EOF_ZERO);
    tx_idle_pct = 67;
    rx_idle_pct = 36;
    random_burst(150, -1, -1);

    // No idling; one long receiver hold-off to back the block up
    drain();
    write_eof_mode(tle_pkg::EOF_KEEP);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_burst(140, 40, -1);

    // Finish with one halting instruction, then a few that must be ignored
    drain();
    write_eof_mode(tle_pkg::EOF_STOP);
    random_burst(10, -1, -1);
    kind = halt_kind_t'($urandom_range(HALT_END, HALT_WALK));
    case (kind)
      HALT_END:
        send_fields(tle_pkg::OP_END, tle_pkg::OFFSET_W'($urandom),
                    tle_pkg::OFFSET_W'($urandom), 8'h00, 1'b0);
      HALT_ASSERT: begin
        send_fields(tle_pkg::OP_SET, 16'h0000, tle_pkg::OFFSET_W'($urandom) | 16'h0001,
                    8'h00, 1'b0);
        send_fields(tle_pkg::OP_ASSERT, 16'h0000, 16'h0000, 8'h00, 1'b0);
      end
      HALT_EOF:
        send_fields(tle_pkg::OP_IN, tle_pkg::OFFSET_W'($urandom_range(0, 8) - 4), 16'h0000,
                    8'h3C, 1'b1);
      HALT_FLAT: begin
        send_fields(tle_pkg::OP_SET, 16'h0000, tle_pkg::OFFSET_W'($urandom) | 16'h0001,
                    8'h00, 1'b0);
        send_fields(tle_pkg::OP_SCAN, 16'h0000, 16'h0000, 8'h00, 1'b0);
      end
      default: begin
        // two nonzero cells half a tape apart: the scan laps without a zero
        send_fields(tle_pkg::OP_SET, 16'h0000, 16'h0011, 8'h00, 1'b0);
        send_fields(tle_pkg::OP_SET, 16'h8000, 16'h0022, 8'h00, 1'b0);
        send_fields(tle_pkg::OP_SCAN, 16'h0000, 16'h8000, 8'h00, 1'b0);
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      it      = rand_instr();
      it.op   = tle_pkg::REQ_TYPE_W'($urandom_range(0, 15));
      it.offs = tle_pkg::OFFSET_W'($urandom);
      send(it);
    end

    drain();
    repeat (16) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Bound the run: clearing pass, one full-lap scan and the stalled traffic fit well inside
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== files.f =====
design/tle_pkg.sv
design/tle_ctrl.sv
design/tle_datapath.sv
design/tape_language_executor_unit.sv
tb/tape_language_executor_unit_tb.sv
